// ===== rtl/core/challenge_table_issue_verify_core_macros.svh =====
// ----------------------------------------------------------------------------
// Challenge table core: assertion macros
// Concurrent assertion shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef CHALLENGE_TABLE_ISSUE_VERIFY_CORE_MACROS_SVH
`define CHALLENGE_TABLE_ISSUE_VERIFY_CORE_MACROS_SVH

// Assertion with explicit clock and active-low reset
`define CTIV_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("challenge table core assertion failed");

// Assertion on the block clock and reset
`define CTIV_ASSERT(lbl, prop) \
  `CTIV_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/core/ctiv_pkg.sv =====
// ----------------------------------------------------------------------------
// Challenge table package
// Sizes, entry layout, result codes and controller types.
// ----------------------------------------------------------------------------
package ctiv_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SLOT_W      = 10;
  localparam int WORD_W      = 32;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [1:0] {
    ST_ISSUED   = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_BAD      = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ISSUE  = 1'b0,
    ACT_VERIFY = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CTRL_CLEAR,
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_DRAIN,
    CTRL_DECIDE
  } ctrl_state_e;

  // One table entry as stored in memory
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] chal;
    logic [WORD_W-1:0] stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;  // write one zero entry during the reset sweep
    logic start;     // latch the request, restart the scan
    logic scan_rd;   // read the next entry
    logic finish;    // resolve, update the table, load the result
  } ctiv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;  // entry counter sits on the last entry
    logic out_free;  // result register can take a new transaction
  } ctiv_sts_t;

  // Low SLOT_W bits of an entry index, zero extended when narrower
  function automatic logic [SLOT_W-1:0] slot_of(logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ctiv_if.sv =====
// ----------------------------------------------------------------------------
// Challenge table channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface ctiv_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] source_address;
  logic [31:0] now_ticks;
  logic [31:0] fresh_value;
  logic [31:0] offered_challenge;

  modport source (
    output valid, action, source_address, now_ticks, fresh_value, offered_challenge,
    input  ready
  );
  modport sink (
    input  valid, action, source_address, now_ticks, fresh_value, offered_challenge,
    output ready
  );
endinterface

interface ctiv_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] challenge_value;
  logic [9:0]  slot_index;

  modport source (
    output valid, status, challenge_value, slot_index,
    input  ready
  );
  modport sink (
    input  valid, status, challenge_value, slot_index,
    output ready
  );
endinterface

// ===== rtl/core/challenge_table_issue_verify_core.sv =====
// An accepted request is latched, the scan reads every table entry, one entry
// per cycle, and the result register is loaded once it has room. No new request
// is taken until the previous one has been resolved.
// Reset: a sweep clears the table; no request is taken until it ends.
// ----------------------------------------------------------------------------
// Challenge table core
// Issues and verifies per-address challenges with oldest-entry replacement.
// ----------------------------------------------------------------------------
`include "challenge_table_issue_verify_core_macros.svh"

module challenge_table_issue_verify_core import ctiv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ctiv_req_if.sink   req_i,
  ctiv_rsp_if.source rsp_o
);

  ctiv_cmd_t cmd;
  ctiv_sts_t sts;
  logic      in_ready;
  status_e   status;

  // Controller
  ctiv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  ctiv_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .action_i            (req_i.action),
    .source_address_i    (req_i.source_address),
    .now_ticks_i         (req_i.now_ticks),
    .fresh_value_i       (req_i.fresh_value),
    .offered_challenge_i (req_i.offered_challenge),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .status_o            (status),
    .challenge_value_o   (rsp_o.challenge_value),
    .slot_index_o        (rsp_o.slot_index)
  );

  assign req_i.ready  = in_ready;
  assign rsp_o.status = status;

  // No new request while the table is being scanned
  `CTIV_ASSERT(a_no_ready_in_scan, cmd.scan_rd |-> !req_i.ready)
  // A result is only loaded when the previous one is gone or leaving
  `CTIV_ASSERT(a_finish_has_room, cmd.finish |-> (!rsp_o.valid || rsp_o.ready))
  // An accepted request starts a scan on the next cycle
  `CTIV_ASSERT(a_accept_starts_scan, (req_i.valid && req_i.ready) |=> cmd.scan_rd)

endmodule

// ===== rtl/core/ctiv_ctrl.sv =====
// ----------------------------------------------------------------------------
// Challenge table controller
// Sequences the reset sweep, the table scan and the final update.
// ----------------------------------------------------------------------------
module ctiv_ctrl import ctiv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctiv_sts_t sts_i,
  output ctiv_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CTRL_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.idx_last) state_d = CTRL_IDLE;
      end
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) state_d = CTRL_DRAIN;
      end
      // last read word is compared here
      CTRL_DRAIN: begin
        state_d = CTRL_DECIDE;
      end
      // wait for room in the result register
      CTRL_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/ctiv_dp.sv =====
// ----------------------------------------------------------------------------
// Challenge table datapath
// Entry memory, scan counter, match and oldest search, result register.
// ----------------------------------------------------------------------------
module ctiv_dp import ctiv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctiv_cmd_t         cmd_i,
  output ctiv_sts_t         sts_o,
  input  logic              action_i,
  input  logic [WORD_W-1:0] source_address_i,
  input  logic [WORD_W-1:0] now_ticks_i,
  input  logic [WORD_W-1:0] fresh_value_i,
  input  logic [WORD_W-1:0] offered_challenge_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output status_e           status_o,
  output logic [WORD_W-1:0] challenge_value_o,
  output logic [SLOT_W-1:0] slot_index_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  entry_t mem_q [NUM_ENTRIES];

  logic [IDX_W-1:0]  idx_q;
  logic              idx_last;
  entry_t            rd_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;

  // latched request
  logic              act_q;
  logic [WORD_W-1:0] addr_q, now_q, fresh_q, offered_q;

  // scan accumulators
  logic              found_q;
  logic [IDX_W-1:0]  match_idx_q;
  logic [WORD_W-1:0] match_chal_q, match_time_q;
  logic [IDX_W-1:0]  old_idx_q;
  logic [WORD_W-1:0] old_time_q;

  // result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_word;

  assign idx_last       = (idx_q == LAST_IDX);
  assign sts_o.idx_last = idx_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Entry counter shared by the reset sweep and the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scan_rd) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_word;
    if (cmd_i.scan_rd) rd_q <= mem_q[idx_q];
    cmp_idx_q <= idx_q;
  end

  // Request latch and scan accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q      <= action_i;
      addr_q     <= source_address_i;
      now_q      <= now_ticks_i;
      fresh_q    <= fresh_value_i;
      offered_q  <= offered_challenge_i;
      found_q    <= 1'b0;
      old_idx_q  <= '0;
      old_time_q <= WORD_MAX;
    end else if (cmp_vld_q) begin
      // first valid entry holding the address
      if (!found_q && rd_q.valid && (rd_q.addr == addr_q)) begin
        found_q      <= 1'b1;
        match_idx_q  <= cmp_idx_q;
        match_chal_q <= rd_q.chal;
        match_time_q <= rd_q.stamp;
      end
      // strictly smaller stamp keeps the lowest index on ties
      if (rd_q.stamp < old_time_q) begin
        old_time_q <= rd_q.stamp;
        old_idx_q  <= cmp_idx_q;
      end
    end
  end

  // Resolution and table write
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = idx_q;
    wr_word  = '0;
    status_d = ST_ISSUED;
    value_d  = '0;
    slot_d   = '0;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
    end else if (act_q == ACT_ISSUE) begin
      status_d = ST_ISSUED;
      if (found_q) begin
        value_d = match_chal_q;
        slot_d  = slot_of(match_idx_q);
      end else begin
        wr_en   = cmd_i.finish;
        wr_idx  = old_idx_q;
        wr_word = '{valid: 1'b1, addr: addr_q, chal: fresh_q, stamp: now_q};
        value_d = fresh_q;
        slot_d  = slot_of(old_idx_q);
      end
    end else if (!found_q) begin
      status_d = ST_NONE;
    end else if (match_chal_q == offered_q) begin
      status_d = ST_ACCEPTED;
      slot_d   = slot_of(match_idx_q);
      wr_en    = cmd_i.finish;
      wr_idx   = match_idx_q;
      wr_word  = '{valid: 1'b1, addr: addr_q, chal: '0, stamp: match_time_q};
    end else begin
      status_d = ST_BAD;
      slot_d   = slot_of(match_idx_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      value_q  <= value_d;
      slot_q   <= slot_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign challenge_value_o = value_q;
  assign slot_index_o      = slot_q;

endmodule

// ===== sim/ctiv_checker.sv =====
// ----------------------------------------------------------------------------
// Challenge table checker
// Watches the request and response channels and keeps a shadow copy of the
// table. It predicts the reply for every accepted request and compares each
// accepted reply, field by field, with the oldest reply still owed.
// ----------------------------------------------------------------------------
module ctiv_checker import ctiv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctiv_req_if         req_i,
  ctiv_rsp_if         rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] chal;
    logic [SLOT_W-1:0] slot;
  } chal_reply_t;

  // Shadow copy of the table
  logic              shadow_valid [NUM_ENTRIES];
  logic [WORD_W-1:0] shadow_addr  [NUM_ENTRIES];
  logic [WORD_W-1:0] shadow_chal  [NUM_ENTRIES];
  logic [WORD_W-1:0] shadow_stamp [NUM_ENTRIES];

  chal_reply_t owed_replies [$];
  chal_reply_t want;
  int unsigned reply_cnt;

  // One line per mismatch, and count it
  task automatic report_mismatch(string what, logic [WORD_W-1:0] got_v,
                                 logic [WORD_W-1:0] want_v);
    $display("mismatch on reply %0d, %s: got %0h, wanted %0h",
             reply_cnt, what, got_v, want_v);
    fail_cnt_o++;
  endtask

  // Apply one request to the shadow table and return the reply it owes
  function automatic chal_reply_t resolve_request(action_e act,
                                                  logic [WORD_W-1:0] addr,
                                                  logic [WORD_W-1:0] ticks,
                                                  logic [WORD_W-1:0] fresh,
                                                  logic [WORD_W-1:0] offered);
    chal_reply_t       r;
    int                hit;
    int                oldest;
    logic [WORD_W-1:0] best_stamp;
    hit = -1;
    for (int k = 0; k < NUM_ENTRIES; k++)
      if (hit < 0 && shadow_valid[k] && shadow_addr[k] == addr) hit = k;
    r.chal = '0;
    r.slot = '0;
    if (act == ACT_ISSUE) begin
      // no holder: evict the smallest stamp, lowest index on a tie
      if (hit < 0) begin
        oldest     = 0;
        best_stamp = WORD_MAX;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          if (shadow_stamp[k] < best_stamp) begin
            best_stamp = shadow_stamp[k];
            oldest     = k;
          end
        end
        shadow_valid[oldest] = 1'b1;
        shadow_addr[oldest]  = addr;
        shadow_stamp[oldest] = ticks;
        shadow_chal[oldest]  = fresh;
        hit = oldest;
      end
      r.status = ST_ISSUED;
      r.chal   = shadow_chal[hit];
      r.slot   = SLOT_W'(hit);
    end else if (hit < 0) begin
      r.status = ST_NONE;
    end else if (shadow_chal[hit] == offered) begin
      shadow_chal[hit] = '0;
      r.status = ST_ACCEPTED;
      r.slot   = SLOT_W'(hit);
    end else begin
      r.status = ST_BAD;
      r.slot   = SLOT_W'(hit);
    end
    return r;
  endfunction

  // Predict on request transactions, compare on response transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        shadow_valid[k] = 1'b0;
        shadow_addr[k]  = '0;
        shadow_chal[k]  = '0;
        shadow_stamp[k] = '0;
      end
      owed_replies.delete();
      reply_cnt  = 0;
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (req_i.valid && req_i.ready)
        owed_replies.push_back(resolve_request(action_e'(req_i.action),
                                               req_i.source_address,
                                               req_i.now_ticks,
                                               req_i.fresh_value,
                                               req_i.offered_challenge));
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("reply with none owed", WORD_W'(rsp_i.status), '0);
        end else begin
          want = owed_replies.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", WORD_W'(rsp_i.status), WORD_W'(want.status));
          if (rsp_i.challenge_value !== want.chal)
            report_mismatch("challenge_value", rsp_i.challenge_value, want.chal);
          if (rsp_i.slot_index !== want.slot)
            report_mismatch("slot_index", WORD_W'(rsp_i.slot_index),
                            WORD_W'(want.slot));
        end
        reply_cnt++;
      end
      pending_o = owed_replies.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Challenge table testbench
// Drives issue and verify requests into the challenge table core: a directed
// opening on the corner cases, then random traffic mostly over a small address
// pool in three idling phases. The checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb import ctiv_pkg::*;;

  localparam int unsigned RAND_ITEMS  = 580;
  localparam int unsigned POOL_N      = 24;
  localparam int unsigned HOLD_AT     = 30;
  localparam int unsigned HOLD_CYCLES = 4 * (NUM_ENTRIES + 3);
  localparam int unsigned LIMIT       = 5_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_cnt;
  int unsigned fail_cnt;
  int unsigned pending;

  // Challenges the requests handed out so far, as far as the stimulus knows
  logic [WORD_W-1:0] granted_chal [logic [WORD_W-1:0]];

  ctiv_req_if req_chan ();
  ctiv_rsp_if rsp_chan ();

  challenge_table_issue_verify_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_chan),
    .rsp_o  (rsp_chan)
  );

  ctiv_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_chan),
    .rsp_i      (rsp_chan),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one request, with an optional idle gap first; returns at a falling edge
  task automatic send_request(action_e act, logic [WORD_W-1:0] addr,
                              logic [WORD_W-1:0] ticks, logic [WORD_W-1:0] fresh,
                              logic [WORD_W-1:0] offered);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, NUM_ENTRIES + 40)
                                        : $urandom_range(1, 8);
      req_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_chan.valid             <= 1'b1;
    req_chan.action            <= act;
    req_chan.source_address    <= addr;
    req_chan.now_ticks         <= ticks;
    req_chan.fresh_value       <= fresh;
    req_chan.offered_challenge <= offered;
    do @(posedge clk_i); while (!req_chan.ready);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Stop offering until every reply owed has come back
  task automatic drain_replies();
    req_chan.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Response side: random ready, plus one long hold that backs the table up
  initial begin : rsp_side
    int unsigned held;
    bit          hold_done;
    hold_done      = 1'b0;
    rsp_chan.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_chan.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
      end
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Request side: directed opening, then random traffic in three phases
  initial begin : req_side
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] ticks;
    logic [WORD_W-1:0] fresh;
    logic [WORD_W-1:0] offered;
    logic [WORD_W-1:0] tick_now;
    logic [WORD_W-1:0] addr_pool [POOL_N];
    action_e           act;
    int unsigned       pick;

    req_chan.valid             = 1'b0;
    req_chan.action            = ACT_ISSUE;
    req_chan.source_address    = '0;
    req_chan.now_ticks         = '0;
    req_chan.fresh_value       = '0;
    req_chan.offered_challenge = '0;
    sent_cnt      = 0;
    tick_now      = 32'd100;
    send_idle_pct = 28;
    recv_idle_pct = 45;
    addr_pool[0]  = '0;
    addr_pool[1]  = '1;
    for (int k = 2; k < POOL_N; k++) addr_pool[k] = $urandom();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: address zero with a zero challenge must not match
    send_request(ACT_VERIFY, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    // all stamps zero: the lowest index wins, even over a valid entry
    send_request(ACT_ISSUE,  32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_ISSUE,  32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_request(ACT_VERIFY, 32'h0000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_ISSUE,  32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
    send_request(ACT_ISSUE,  32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
    // a repeated issue returns the stored value and keeps the stamp
    send_request(ACT_ISSUE,  32'hFFFF_FFFF, 32'h5, 32'hDEAD_BEEF, 32'h0);
    // zero challenge: accepted, and accepted again after being cleared
    send_request(ACT_VERIFY, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_request(ACT_VERIFY, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_request(ACT_VERIFY, 32'h0000_0000, 32'h0, 32'h0, 32'h1234_5679);
    send_request(ACT_VERIFY, 32'h0000_0000, 32'h0, 32'h0, 32'h1234_5678);
    // issue after an accept returns the cleared zero
    send_request(ACT_ISSUE,  32'h0000_0000, 32'h7, 32'hAAAA_5555, 32'h0);
    send_request(ACT_VERIFY, 32'h0000_0000, 32'h0, 32'h0, 32'h1234_5678);
    send_request(ACT_ISSUE,  32'h8000_0001, 32'h7FFF_FFFF, 32'h0F0F_0F0F, 32'h0);
    send_request(ACT_VERIFY, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0F0F_0F0F);
    send_request(ACT_VERIFY, 32'h7FFF_FFFE, 32'h0, 32'h0, 32'h0);
    drain_replies();

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        drain_replies();
        send_idle_pct = 45;
        recv_idle_pct = 28;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        drain_replies();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // mostly a small pool so issues and verifies meet the same entries
      addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_N - 1)]
                                          : $urandom();
      act  = action_e'($urandom_range(0, 1));

      // zero stamps make low entries the oldest again
      tick_now = tick_now + $urandom_range(0, 40);
      pick = $urandom_range(0, 99);
      if (pick < 8)       ticks = '0;
      else if (pick < 12) ticks = '1;
      else if (pick < 17) ticks = $urandom();
      else                ticks = tick_now;

      fresh = ($urandom_range(0, 99) < 6) ? '0 : $urandom();

      pick = $urandom_range(0, 99);
      if (granted_chal.exists(addr) && pick < 60)
        offered = granted_chal[addr];
      else if (pick < 70)
        offered = '0;
      else if (granted_chal.exists(addr) && pick < 80)
        offered = granted_chal[addr] ^ (32'd1 << $urandom_range(0, 31));
      else
        offered = $urandom();

      if (act == ACT_ISSUE) begin
        if (!granted_chal.exists(addr)) granted_chal[addr] = fresh;
      end else if (granted_chal.exists(addr) && granted_chal[addr] == offered) begin
        granted_chal[addr] = '0;
      end

      send_request(act, addr, ticks, fresh, offered);
    end

    drain_replies();
    repeat (NUM_ENTRIES + 8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ctiv_pkg.sv
rtl/core/ctiv_if.sv
rtl/core/ctiv_ctrl.sv
rtl/core/ctiv_dp.sv
rtl/core/challenge_table_issue_verify_core.sv
sim/ctiv_checker.sv
sim/tb.sv
